### design/qmn_pkg.sv
// ----------------------------------------------------------------------------
// qmn_pkg: shared constants and types for the quaternion product normaliser
// Holds default widths and the root stage count.
// ----------------------------------------------------------------------------
`default_nettype none

package qmn_pkg;

  localparam int unsigned DefCompWidth = 16;
  localparam int unsigned DefFracBits  = 14;

  // the largest normalised magnitude lies in [2^29, 2^30)
  localparam int unsigned NormWidth = 30;
  // sum of four squares stays below 2^62
  localparam int unsigned SumWidth  = 62;
  localparam int unsigned RootWidth = 31;
  localparam int unsigned RootSteps = 31;

endpackage

`default_nettype wire

### design/qmn_divide.sv
// ----------------------------------------------------------------------------
// qmn_divide: pipelined restoring divider, one quotient bit per stage
// Computes min(2^FRAC, floor(num * 2^FRAC / den)) with stall support.
// ----------------------------------------------------------------------------
`default_nettype none

module qmn_divide import qmn_pkg::*; #(
  parameter int unsigned FRACTION_BITS = DefFracBits
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire logic [NormWidth-1:0]   num_i,
  input  wire logic [RootWidth-1:0]   den_i,
  output logic                        valid_o,
  output logic [FRACTION_BITS:0]      quot_o
);

  // num <= len (len >= largest magnitude), so the quotient fits FRACTION_BITS+2 bits
  localparam int unsigned QW = FRACTION_BITS + 2;
  localparam int unsigned RW = RootWidth + 1;

  logic [QW-1:0]        vld_q;
  logic [RW-1:0]        rem_q [QW];
  logic [RootWidth-1:0] den_q [QW];
  logic [QW-1:0]        quo_q [QW];
  logic [QW-1:0]        sub_q [QW];   // remaining numerator bits, MSB first
  logic [RW-1:0]        rem_d [QW];
  logic [QW-1:0]        quo_d [QW];

  // numerator*2^FRAC fed bitwise: top part is num itself (quotient msb
  // positions start at num >> ... handled by loading num into remainder)
  always_comb begin
    for (int s = 0; s < QW; s++) begin
      logic [RW-1:0]        r_in;
      logic [RootWidth-1:0] d_in;
      logic [QW-1:0]        q_in;
      logic [RW:0]          trial;
      logic                 b_in;
      if (s == 0) begin
        // first step takes num itself as its trial remainder
        r_in = '0;
        d_in = den_i;
        q_in = '0;
        b_in = 1'b0;
      end else begin
        r_in = rem_q[s-1];
        d_in = den_q[s-1];
        q_in = quo_q[s-1];
        b_in = sub_q[s-1][QW-1];
      end
      if (s == 0) begin
        trial = {3'b0, num_i[NormWidth-1:0]};
      end else begin
        trial = {r_in, b_in};
      end
      if (trial >= {2'b0, d_in}) begin
        rem_d[s] = RW'(trial - {2'b0, d_in});
        quo_d[s] = {q_in[QW-2:0], 1'b1};
      end else begin
        rem_d[s] = RW'(trial);
        quo_d[s] = {q_in[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QW; s++) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        den_q[s] <= (s == 0) ? den_i : den_q[s-1];
        sub_q[s] <= (s == 0) ? '0 : {sub_q[s-1][QW-2:0], 1'b0};
      end
    end
  end

  // first stage produced the integer bit (num/den), later ones the fraction
  always_comb begin
    logic [QW-1:0] q;
    q = quo_q[QW-1];
    if (q[QW-1:1] > ((QW-1)'(1) << FRACTION_BITS))
      quot_o = (FRACTION_BITS+1)'(1) << FRACTION_BITS;
    else
      quot_o = q[FRACTION_BITS+1:1];
  end

  assign valid_o = vld_q[QW-1];

endmodule

`default_nettype wire

### design/quaternion_multiply_normalize.sv
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize: Hamilton product scaled to unit length
// Multiplies two fixed-point quaternions and divides by the product length.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  in      | in_valid_i, in_stall_o, a_*, b_* | into block
//  out     | out_valid_o, out_stall_i, r_*    | out of block
//
// One item per cycle while the output is not stalled. The pipeline has
// 6 front stages, RootSteps root stages, then FRACTION_BITS+2 divider
// stages and an output stage.
// Reset clears only the valid bits. A stall freezes the whole pipeline;
// input is taken whenever the output register is free or being drained.
`default_nettype none

module quaternion_multiply_normalize import qmn_pkg::*; #(
  parameter int unsigned COMPONENT_WIDTH = DefCompWidth,
  parameter int unsigned FRACTION_BITS   = DefFracBits
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [COMPONENT_WIDTH-1:0] a_w_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] a_x_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] a_y_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] a_z_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] b_w_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] b_x_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] b_y_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] b_z_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [COMPONENT_WIDTH-1:0]      r_w_o,
  output logic signed [COMPONENT_WIDTH-1:0]      r_x_o,
  output logic signed [COMPONENT_WIDTH-1:0]      r_y_o,
  output logic signed [COMPONENT_WIDTH-1:0]      r_z_o,
  output logic                                   zero_length_o
);

  localparam int unsigned CW   = COMPONENT_WIDTH;
  localparam int unsigned Grd  = (2*CW > 62) ? 2*CW - 62 : 0;
  localparam int unsigned TW   = 2*CW - Grd;        // term width
  localparam int unsigned PW   = TW + 2;            // sum of four terms
  localparam int unsigned MW   = PW;                // magnitude width
  localparam int unsigned SW   = (MW > NormWidth) ? MW : NormWidth;
  localparam int unsigned ShW  = $clog2(SW + NormWidth + 1);
  localparam int unsigned DivLat = FRACTION_BITS + 2;
  localparam int unsigned SideLat = RootSteps + DivLat;

  // whole pipeline advances unless a valid result sits stalled at the output
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // ---- stage 1: sixteen products ----
  logic         v1_q;
  logic signed [TW-1:0] t_q [16];
  logic signed [CW-1:0] av [4], bv [4];
  assign av = '{a_w_i, a_x_i, a_y_i, a_z_i};
  assign bv = '{b_w_i, b_x_i, b_y_i, b_z_i};

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          logic signed [2*CW-1:0] pr;
          pr = av[i] * bv[j];
          // divide toward zero by 2^Grd
          if (Grd > 0 && pr < 0)
            pr = pr + (2*CW)'((64'd1 << Grd) - 1);
          t_q[i*4+j] <= TW'(pr >>> Grd);
        end
      end
    end
  end

  // ---- stage 2: Hamilton sums ----
  logic         v2_q;
  logic signed [PW-1:0] p_q [4];
  function automatic logic signed [PW-1:0] sx(input logic signed [TW-1:0] t);
    sx = PW'(t);
  endfunction
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= sx(t_q[0])  - sx(t_q[5])  - sx(t_q[10]) - sx(t_q[15]);
      p_q[1] <= sx(t_q[1])  + sx(t_q[4])  + sx(t_q[11]) - sx(t_q[14]);
      p_q[2] <= sx(t_q[2])  + sx(t_q[8])  + sx(t_q[13]) - sx(t_q[7]);
      p_q[3] <= sx(t_q[3])  + sx(t_q[12]) + sx(t_q[6])  - sx(t_q[9]);
    end
  end

  // ---- stage 3: magnitudes and leading-one of their OR ----
  logic         v3_q;
  logic [MW-1:0] m_q [4];
  logic [3:0]    neg_q;
  logic [ShW-1:0] lead_q;
  logic          zero_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [MW-1:0] mm [4];
      logic [MW-1:0] orv;
      logic [ShW-1:0] ld;
      orv = '0;
      for (int i = 0; i < 4; i++) begin
        mm[i] = p_q[i][PW-1] ? MW'(-p_q[i]) : MW'(p_q[i]);
        orv   = orv | mm[i];
        neg_q[i] <= p_q[i][PW-1];
        m_q[i]   <= mm[i];
      end
      // msb of the OR equals msb of the largest magnitude
      ld = '0;
      for (int b = 0; b < MW; b++)
        if (orv[b]) ld = ShW'(b);
      lead_q <= ld;
      zero_q <= (orv == '0);
    end
  end

  // ---- stage 4: shared shift to put the leading one at bit 29 ----
  logic          v4_q;
  logic [NormWidth-1:0] n_q [4];
  logic [3:0]    neg4_q;
  logic          zero4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        logic [SW+NormWidth-1:0] w;
        w = (SW+NormWidth)'(m_q[i]);
        if (lead_q >= ShW'(NormWidth-1))
          n_q[i] <= NormWidth'(w >> (lead_q - ShW'(NormWidth-1)));
        else
          n_q[i] <= NormWidth'(w << (ShW'(NormWidth-1) - lead_q));
      end
      neg4_q  <= neg_q;
      zero4_q <= zero_q;
    end
  end

  // ---- stages 5 and 6: squares (30x30 each), then their sum ----
  logic          v5_q, v6_q;
  logic [2*NormWidth-1:0] sq_q [4];
  logic [SumWidth-1:0]    s_q;
  logic [NormWidth-1:0]   n5_q [4], n6_q [4];
  logic [3:0]    neg5_q, neg6_q;
  logic          zero5_q, zero6_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq_q[i] <= (2*NormWidth)'(n_q[i]) * (2*NormWidth)'(n_q[i]);
        n5_q[i] <= n_q[i];
      end
      neg5_q  <= neg4_q;
      zero5_q <= zero4_q;
      s_q <= SumWidth'(sq_q[0]) + SumWidth'(sq_q[1]) + SumWidth'(sq_q[2])
           + SumWidth'(sq_q[3]);
      n6_q    <= n5_q;
      neg6_q  <= neg5_q;
      zero6_q <= zero5_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q} <= '0;
    end else if (en) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q} <= {in_valid_i, v1_q, v2_q, v3_q, v4_q, v5_q};
    end
  end

  // ---- root stages: one result bit per stage ----
  logic [SumWidth-1:0]  rrem_q [RootSteps];
  logic [RootWidth-1:0] rroot_q [RootSteps];
  logic [NormWidth-1:0] rn_q [RootSteps][4];
  logic [RootSteps-1:0] rv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < RootSteps; s++) begin
        logic [SumWidth:0] rem, root, bitv;
        rem  = (s == 0) ? (SumWidth+1)'(s_q) : (SumWidth+1)'(rrem_q[s-1]);
        root = (s == 0) ? '0
                        : (SumWidth+1)'(rroot_q[s-1]) << (2*(RootSteps-s));
        bitv = (SumWidth+1)'(1) << (2*(RootSteps-1-s));
        // trial term 2*root*bit: partial root shifted by twice the steps left
        if (rem >= root + bitv) begin
          rrem_q[s]  <= SumWidth'(rem - root - bitv);
          rroot_q[s] <= (s == 0) ? RootWidth'(1)
                                 : RootWidth'({rroot_q[s-1], 1'b1});
        end else begin
          rrem_q[s]  <= SumWidth'(rem);
          rroot_q[s] <= (s == 0) ? '0 : RootWidth'({rroot_q[s-1], 1'b0});
        end
        rn_q[s] <= (s == 0) ? n6_q : rn_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q <= '0;
    else if (en) rv_q <= {rv_q[RootSteps-2:0], v6_q};
  end

  // ---- dividers, one per component ----
  logic [RootWidth-1:0] len;
  assign len = (rroot_q[RootSteps-1] == '0) ? RootWidth'(1) : rroot_q[RootSteps-1];

  logic [3:0]           dv;
  logic [FRACTION_BITS:0] qt [4];
  for (genvar g = 0; g < 4; g++) begin : g_div
    qmn_divide #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clk_i, .rst_ni, .en_i(en), .valid_i(rv_q[RootSteps-1]),
      .num_i(rn_q[RootSteps-1][g]), .den_i(len),
      .valid_o(dv[g]), .quot_o(qt[g])
    );
  end

  // sign and zero flag ride a side delay line matching root+divide
  logic [3:0] sneg_q [SideLat];
  logic       szero_q [SideLat];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < SideLat; s++) begin
        sneg_q[s]  <= (s == 0) ? neg6_q  : sneg_q[s-1];
        szero_q[s] <= (s == 0) ? zero6_q : szero_q[s-1];
      end
    end
  end

  // ---- output register ----
  logic signed [CW-1:0] r_q [4];
  logic                 ov_q, oz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= dv[0];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        logic [CW:0] mq;
        mq = (CW+1)'(qt[i]);
        if (szero_q[SideLat-1]) r_q[i] <= '0;
        else if (sneg_q[SideLat-1][i]) r_q[i] <= CW'(-mq);
        else r_q[i] <= CW'(mq);
      end
      oz_q <= szero_q[SideLat-1];
    end
  end

  assign out_valid_o   = ov_q;
  assign r_w_o         = r_q[0];
  assign r_x_o         = r_q[1];
  assign r_y_o         = r_q[2];
  assign r_z_o         = r_q[3];
  assign zero_length_o = oz_q;

endmodule

`default_nettype wire

### design/qmn_checker.sv
// ----------------------------------------------------------------------------
// qmn_checker: port-level checks for the quaternion normaliser
// Watches handshake and result consistency; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qmn_checker import qmn_pkg::*; #(
  parameter int unsigned COMPONENT_WIDTH = DefCompWidth
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic signed [COMPONENT_WIDTH-1:0] r_w_o,
  input wire logic signed [COMPONENT_WIDTH-1:0] r_x_o,
  input wire logic signed [COMPONENT_WIDTH-1:0] r_y_o,
  input wire logic signed [COMPONENT_WIDTH-1:0] r_z_o,
  input wire logic zero_length_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(r_w_o))
    else $error("stalled result changed");

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_length_o |-> r_w_o == 0 && r_x_o == 0 && r_y_o == 0 && r_z_o == 0)
    else $error("zero length with nonzero component");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

endmodule

bind quaternion_multiply_normalize qmn_checker #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_chk (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i,
  .r_w_o, .r_x_o, .r_y_o, .r_z_o, .zero_length_o
);

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for quaternion_multiply_normalize
// Sends quaternion pairs through the valid/stall input channel and predicts
// each normalised Hamilton product, comparing every output item field by
// field as it arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import qmn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = DefCompWidth;
  localparam int unsigned FB = DefFracBits;
  // 6 front stages + root steps + divider + output
  localparam int unsigned Latency = 6 + RootSteps + FB + 2 + 1;

  typedef logic signed [CW-1:0] comp_t;
  typedef struct packed {
    comp_t w, x, y, z;
  } quat_t;
  typedef struct packed {
    quat_t q;
    logic  zero;
  } norm_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  comp_t a_w_i = '0, a_x_i = '0, a_y_i = '0, a_z_i = '0;
  comp_t b_w_i = '0, b_x_i = '0, b_y_i = '0, b_z_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  comp_t r_w_o, r_x_o, r_y_o, r_z_o;
  logic  zero_length_o;

  // idling percentages for the sender and the receiver
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  norm_t       expected_products[$];
  int unsigned mismatches = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  quaternion_multiply_normalize DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .a_w_i, .a_x_i, .a_y_i, .a_z_i, .b_w_i, .b_x_i, .b_y_i, .b_z_i,
    .out_valid_o, .out_stall_i,
    .r_w_o, .r_x_o, .r_y_o, .r_z_o, .zero_length_o
  );

  // Exact Hamilton product, then shared normalising shift, bitwise root and
  // saturating divide, as the block is specified.
  function automatic norm_t normalised_product(quat_t a, quat_t b);
    longint signed   p[4];
    longint unsigned m[4];
    longint unsigned mx, s, len, root, rem, bits, qt, one;
    norm_t           r;
    p[0] = longint'(a.w)*b.w - longint'(a.x)*b.x - longint'(a.y)*b.y - longint'(a.z)*b.z;
    p[1] = longint'(a.w)*b.x + longint'(a.x)*b.w + longint'(a.y)*b.z - longint'(a.z)*b.y;
    p[2] = longint'(a.w)*b.y + longint'(a.y)*b.w + longint'(a.z)*b.x - longint'(a.x)*b.z;
    p[3] = longint'(a.w)*b.z + longint'(a.z)*b.w + longint'(a.x)*b.y - longint'(a.y)*b.x;
    r = '0;
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      m[i] = (p[i] < 0) ? -p[i] : p[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      r.zero = 1'b1;
      return r;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 4; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 4; i++) m[i] <<= 1;
    end
    s = 0;
    for (int i = 0; i < 4; i++) s += m[i] * m[i];
    root = 0;
    rem = s;
    bits = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= root + bits) begin
        rem -= root + bits;
        root = (root >> 1) + bits;
      end else begin
        root >>= 1;
      end
      bits >>= 2;
    end
    len = (root == 0) ? 1 : root;
    one = 64'd1 << FB;
    for (int i = 0; i < 4; i++) begin
      qt = (m[i] << FB) / len;
      if (qt > one) qt = one;
      if (p[i] < 0) qt = -qt;
      case (i)
        0: r.q.w = comp_t'(qt);
        1: r.q.x = comp_t'(qt);
        2: r.q.y = comp_t'(qt);
        default: r.q.z = comp_t'(qt);
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
    mismatches++;
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Drives one pair and holds it until accepted; a random gap may come first.
  task automatic send_pair(quat_t a, quat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {a_w_i, a_x_i, a_y_i, a_z_i} <= a;
    {b_w_i, b_x_i, b_y_i, b_z_i} <= b;
    expected_products.push_back(normalised_product(a, b));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic quat_t random_quat();
    quat_t q;
    case ($urandom_range(3))
      0: q = {4{comp_t'($urandom_range(32767))}} ^ quat_t'({$urandom, $urandom});
      1: q = {comp_t'($urandom_range(33) - 16), comp_t'($urandom_range(33) - 16),
              comp_t'($urandom_range(33) - 16), comp_t'($urandom_range(33) - 16)};
      default: q = quat_t'({$urandom, $urandom});
    endcase
    // occasionally a pure axis or a full-scale corner
    if ($urandom_range(9) == 0) q = {comp_t'(16384), comp_t'(0), comp_t'(0), comp_t'(0)};
    if ($urandom_range(19) == 0) q = {4{comp_t'(-32768)}};
    return q;
  endfunction

  // Receiver: random stall, checks each accepted result against the oldest.
  always @(posedge clk_i) begin
    norm_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_products.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected output item", $realtime);
      end else begin
        want = expected_products.pop_front();
        if (r_w_o !== want.q.w) report_mismatch("r_w", r_w_o, want.q.w);
        if (r_x_o !== want.q.x) report_mismatch("r_x", r_x_o, want.q.x);
        if (r_y_o !== want.q.y) report_mismatch("r_y", r_y_o, want.q.y);
        if (r_z_o !== want.q.z) report_mismatch("r_z", r_z_o, want.q.z);
        if (zero_length_o !== want.zero)
          report_mismatch("zero_length", CW'(zero_length_o), CW'(want.zero));
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Extremes, zero product, unit rotations and saturating quotients.
  task automatic test_directed();
    quat_t one_q, i_q, j_q;
    one_q = {comp_t'(16384), comp_t'(0), comp_t'(0), comp_t'(0)};
    i_q   = {comp_t'(0), comp_t'(16384), comp_t'(0), comp_t'(0)};
    j_q   = {comp_t'(0), comp_t'(0), comp_t'(16384), comp_t'(0)};
    send_pair('0, '0);
    send_pair(one_q, '0);
    send_pair(one_q, one_q);
    send_pair(i_q, j_q);
    send_pair(j_q, i_q);
    send_pair(i_q, i_q);
    send_pair({4{comp_t'(32767)}}, {4{comp_t'(32767)}});
    send_pair({4{comp_t'(-32768)}}, {4{comp_t'(-32768)}});
    send_pair({4{comp_t'(-32768)}}, {4{comp_t'(32767)}});
    send_pair({comp_t'(-32768), comp_t'(0), comp_t'(0), comp_t'(0)}, one_q);
    send_pair({comp_t'(1), comp_t'(0), comp_t'(0), comp_t'(0)},
              {comp_t'(1), comp_t'(0), comp_t'(0), comp_t'(0)});
    send_pair({4{comp_t'(1)}}, {4{comp_t'(-1)}});
    send_pair({4{comp_t'(-1)}}, {4{comp_t'(-1)}});
    // small integer components whose length has an exact root
    send_pair({comp_t'(3), comp_t'(4), comp_t'(0), comp_t'(0)}, one_q);
    send_pair({comp_t'(1), comp_t'(1), comp_t'(1), comp_t'(1)}, one_q);
    send_pair({comp_t'(12345), comp_t'(-7), comp_t'(3), comp_t'(-32768)},
              {comp_t'(-1), comp_t'(32767), comp_t'(-16384), comp_t'(5)});
    // all bits toggled on each field
    send_pair({4{comp_t'(16'h5555)}}, {4{comp_t'(16'hAAAA)}});
    send_pair({4{comp_t'(16'hAAAA)}}, {4{comp_t'(16'h5555)}});
  endtask

  task automatic test_random(int unsigned count);
    for (int unsigned n = 0; n < count; n++) send_pair(random_quat(), random_quat());
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 36;
    recv_idle_pct = 85;
    test_directed();
    test_random(640);
    send_idle_pct = 85;
    recv_idle_pct = 36;
    test_random(640);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(650);
    drain();
    if (mismatches == 0 && expected_products.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // generous bound: every item waiting out long gaps and stalls
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
design/qmn_pkg.sv
design/qmn_divide.sv
design/quaternion_multiply_normalize.sv
design/qmn_checker.sv
dv/tb.sv
